// ----- src/cnmf_pkg.sv -----
// Types, codes and helpers shared by the CAN NM state machine modules.
package cnmf_pkg;

    localparam int TICK_WIDTH_DEF      = 16;
    localparam int IMMEDIATE_COUNT_DEF = 5;
    localparam int CFG_W               = 16;
    localparam int BYTE_W              = 8;
    localparam int DLC_W               = 4;
    localparam int NUM_TIMERS          = 6;

    localparam int T_TIMEOUT = 0;
    localparam int T_MSG     = 1;
    localparam int T_REPEAT  = 2;
    localparam int T_WAIT    = 3;
    localparam int T_WAKE    = 4;
    localparam int T_DIAG    = 5;

    localparam logic [BYTE_W-1:0] CTL_REPEAT  = 8'h01;
    localparam logic [BYTE_W-1:0] CTL_ACTIVE  = 8'h10;
    localparam logic [BYTE_W-1:0] RX_CTL_MASK = 8'h11;
    localparam logic [DLC_W-1:0]  FULL_DLC    = 4'd8;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_SLEEP   = 3'd1,
        MODE_REPEAT  = 3'd2,
        MODE_NORMAL  = 3'd3,
        MODE_READY   = 3'd4,
        MODE_PREPARE = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        FN_TICK       = 3'd0,
        FN_MAIN       = 3'd1,
        FN_START      = 3'd2,
        FN_STOP       = 3'd3,
        FN_WAKEUP     = 3'd4,
        FN_RELEASE    = 3'd5,
        FN_SLEEPED    = 3'd6,
        FN_TX_CONFIRM = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        REG_NODE_ID       = 3'd0,
        REG_MSG_CYCLE     = 3'd1,
        REG_IMM_CYCLE     = 3'd2,
        REG_TIMEOUT       = 3'd3,
        REG_REPEAT_MSG    = 3'd4,
        REG_WAIT_SLEEP    = 3'd5,
        REG_WAKEUP_HOLD   = 3'd6,
        REG_DIAG_HOLD     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] node_id;
        logic [CFG_W-1:0]  message_cycle_ticks;
        logic [CFG_W-1:0]  immediate_cycle_ticks;
        logic [CFG_W-1:0]  timeout_ticks;
        logic [CFG_W-1:0]  repeat_message_ticks;
        logic [CFG_W-1:0]  wait_bus_sleep_ticks;
        logic [CFG_W-1:0]  wakeup_hold_ticks;
        logic [CFG_W-1:0]  diag_hold_ticks;
    } cfg_t;

    typedef struct packed {
        func_t             func;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_id_low;
        logic [BYTE_W-1:0] rx_byte0;
        logic [BYTE_W-1:0] rx_byte1;
        logic [DLC_W-1:0]  rx_length;
        logic              diag_event;
        logic              bus_wakeup;
    } item_t;

    typedef struct packed {
        mode_t             nm_mode;
        logic              tx_send;
        logic [BYTE_W-1:0] tx_data0;
        logic [BYTE_W-1:0] tx_data1;
        logic              tx_repeat_flag;
        logic              app_comm_on;
        logic              tx_allowed;
        logic              may_sleep;
        logic              clear_buffers;
        logic              wakeup_consumed;
        logic              diag_consumed;
    } result_t;

    // enables of timeout, message cycle, repeat and wait timers for a mode
    function automatic logic [3:0] mode_en(input mode_t m);
        logic [3:0] e;
        e = '0;
        e[T_TIMEOUT] = (m == MODE_REPEAT) || (m == MODE_NORMAL) || (m == MODE_READY);
        e[T_MSG]     = (m == MODE_REPEAT) || (m == MODE_NORMAL);
        e[T_REPEAT]  = (m == MODE_REPEAT);
        e[T_WAIT]    = (m == MODE_PREPARE);
        return e;
    endfunction

    function automatic logic is_active_mode(input mode_t m);
        return (m == MODE_REPEAT) || (m == MODE_NORMAL) || (m == MODE_READY);
    endfunction

endpackage

// ----- src/can_network_management_fsm_top.sv -----
// Top level of the CAN network-management node state machine.
//
// Event words enter on the input channel (in_valid / in_stall) with the
// fields func, rx_*, diag_event and bus_wakeup. Each word yields exactly one
// result word on the output channel (out_valid / out_stall): mode, NM frame
// bytes and status flags. A word taken into the input register is handled
// once the result register is free, and its result is registered there.
// One word per cycle is sustained while out_stall is low; the event handler
// is one pass of logic between the input register and the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more word, and in_stall rises while both are full.
// Configuration words (cfg_valid / cfg_ready, cfg_index, cfg_data) are taken
// every cycle and are meant to be written only while the block is idle.
// Reset puts the node in the off state with all timers cleared and loads
// the default register values; both channels come up empty.
module can_network_management_fsm_top
    import cnmf_pkg::*;
#(
    parameter int TICK_WIDTH      = TICK_WIDTH_DEF,
    parameter int IMMEDIATE_COUNT = IMMEDIATE_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        func,
    input  logic              rx_valid,
    input  logic [BYTE_W-1:0] rx_id_low,
    input  logic [BYTE_W-1:0] rx_byte0,
    input  logic [BYTE_W-1:0] rx_byte1,
    input  logic [DLC_W-1:0]  rx_length,
    input  logic              diag_event,
    input  logic              bus_wakeup,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        nm_mode,
    output logic              tx_send,
    output logic [BYTE_W-1:0] tx_data0,
    output logic [BYTE_W-1:0] tx_data1,
    output logic              tx_repeat_flag,
    output logic              app_comm_on,
    output logic              tx_allowed,
    output logic              may_sleep,
    output logic              clear_buffers,
    output logic              wakeup_consumed,
    output logic              diag_consumed
);

    cfg_t    cfg;
    item_t   item_reg;
    result_t res_comb, res_reg;
    logic    in_vld_reg;
    logic    out_vld_reg;
    logic    fire;

    assign fire     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;

    cnmf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cnmf_engine #(
        .TICK_WIDTH      (TICK_WIDTH),
        .IMMEDIATE_COUNT (IMMEDIATE_COUNT)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            if (fire)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.func       <= func_t'(func);
            item_reg.rx_valid   <= rx_valid;
            item_reg.rx_id_low  <= rx_id_low;
            item_reg.rx_byte0   <= rx_byte0;
            item_reg.rx_byte1   <= rx_byte1;
            item_reg.rx_length  <= rx_length;
            item_reg.diag_event <= diag_event;
            item_reg.bus_wakeup <= bus_wakeup;
        end
        if (fire)
            res_reg <= res_comb;
    end

    assign out_valid       = out_vld_reg;
    assign nm_mode         = res_reg.nm_mode;
    assign tx_send         = res_reg.tx_send;
    assign tx_data0        = res_reg.tx_data0;
    assign tx_data1        = res_reg.tx_data1;
    assign tx_repeat_flag  = res_reg.tx_repeat_flag;
    assign app_comm_on     = res_reg.app_comm_on;
    assign tx_allowed      = res_reg.tx_allowed;
    assign may_sleep       = res_reg.may_sleep;
    assign clear_buffers   = res_reg.clear_buffers;
    assign wakeup_consumed = res_reg.wakeup_consumed;
    assign diag_consumed   = res_reg.diag_consumed;

`ifndef NO_ASSERTIONS
    // a waiting event is never dropped while the result register is blocked
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && out_vld_reg && out_stall) |=> in_vld_reg)
        else $error("pending event lost under output stall");

    // frames only go out from the awake states
    a_send_awake: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_send) |-> tx_allowed)
        else $error("NM frame sent outside repeat, normal or ready sleep");

    a_rep_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_repeat_flag) |-> (tx_send && nm_mode != MODE_OFF))
        else $error("repeat flag without a sent frame");

    // buffer clear only on the fall into bus sleep
    a_clear_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_buffers) |-> (nm_mode == MODE_SLEEP && !app_comm_on && !tx_send))
        else $error("buffer clear outside entry to bus sleep");
`endif

endmodule

// ----- src/cnmf_cfg.sv -----
// Configuration register file of the CAN NM state machine.
module cnmf_cfg
    import cnmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id               <= 8'd0;
            cfg_reg.message_cycle_ticks   <= 16'd100;
            cfg_reg.immediate_cycle_ticks <= 16'd20;
            cfg_reg.timeout_ticks         <= 16'd200;
            cfg_reg.repeat_message_ticks  <= 16'd150;
            cfg_reg.wait_bus_sleep_ticks  <= 16'd200;
            cfg_reg.wakeup_hold_ticks     <= 16'd100;
            cfg_reg.diag_hold_ticks       <= 16'd500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_NODE_ID:     cfg_reg.node_id               <= cfg_data[BYTE_W-1:0];
                REG_MSG_CYCLE:   cfg_reg.message_cycle_ticks   <= cfg_data;
                REG_IMM_CYCLE:   cfg_reg.immediate_cycle_ticks <= cfg_data;
                REG_TIMEOUT:     cfg_reg.timeout_ticks         <= cfg_data;
                REG_REPEAT_MSG:  cfg_reg.repeat_message_ticks  <= cfg_data;
                REG_WAIT_SLEEP:  cfg_reg.wait_bus_sleep_ticks  <= cfg_data;
                REG_WAKEUP_HOLD: cfg_reg.wakeup_hold_ticks     <= cfg_data;
                REG_DIAG_HOLD:   cfg_reg.diag_hold_ticks       <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- src/cnmf_engine.sv -----
// NM state registers, tick timers and the combinational event handler.
module cnmf_engine
    import cnmf_pkg::*;
#(
    parameter int TICK_WIDTH      = TICK_WIDTH_DEF,
    parameter int IMMEDIATE_COUNT = IMMEDIATE_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    localparam int CW = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

    typedef logic [NUM_TIMERS-1:0][TICK_WIDTH-1:0] cnt_arr_t;

    mode_t                  mode_reg, mode_next;
    cnt_arr_t               cnt_reg, cnt_next;
    logic [NUM_TIMERS-1:0]  en_reg, en_next;
    logic                   work_on_reg, work_on_next;
    logic                   wake_hold_reg, wake_hold_next;
    logic                   local_req_reg, local_req_next;
    logic                   diag_hold_reg, diag_hold_next;
    logic                   rx_seen_reg, rx_seen_next;
    logic                   tx_seen_reg, tx_seen_next;
    logic [BYTE_W-1:0]      rx_ctl_reg, rx_ctl_next;
    logic [BYTE_W-1:0]      tx_ctl_reg, tx_ctl_next;
    logic [BYTE_W-1:0]      imm_reg, imm_next;
    logic                   app_en_reg, app_en_next;

    function automatic logic ge(input logic [TICK_WIDTH-1:0] c, input logic [CFG_W-1:0] t);
        return CW'(c) >= CW'(t);
    endfunction

    function automatic logic gt(input logic [TICK_WIDTH-1:0] c, input logic [CFG_W-1:0] t);
        return CW'(c) > CW'(t);
    endfunction

    function automatic logic [TICK_WIDTH-1:0] ld(input logic [CFG_W-1:0] v);
        return TICK_WIDTH'(CW'(v));
    endfunction

    always_comb
    begin
        logic net_req;
        logic net_rel;
        logic passive;
        logic rx_rep;
        logic enter_rep;
        logic enter_act;

        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        en_next        = en_reg;
        work_on_next   = work_on_reg;
        wake_hold_next = wake_hold_reg;
        local_req_next = local_req_reg;
        diag_hold_next = diag_hold_reg;
        rx_seen_next   = rx_seen_reg;
        tx_seen_next   = tx_seen_reg;
        rx_ctl_next    = rx_ctl_reg;
        tx_ctl_next    = tx_ctl_reg;
        imm_next       = imm_reg;
        app_en_next    = app_en_reg;
        res            = '0;
        net_req        = 1'b0;
        net_rel        = 1'b0;
        passive        = 1'b0;
        rx_rep         = 1'b0;
        enter_rep      = 1'b0;
        enter_act      = 1'b0;

        unique case (item.func)
            FN_TICK:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (en_reg[i] && (cnt_reg[i] != '1))
                        cnt_next[i] = cnt_reg[i] + 1'b1;
                end
            end
            FN_MAIN:
            begin
                rx_seen_next = item.rx_valid;
                rx_ctl_next  = item.rx_valid ? (item.rx_byte1 & RX_CTL_MASK) : '0;
                if (item.diag_event)
                begin
                    res.diag_consumed  = 1'b1;
                    cnt_next[T_DIAG]   = '0;
                    en_next[T_DIAG]    = 1'b1;
                    diag_hold_next     = 1'b1;
                end
                if (wake_hold_next && gt(cnt_next[T_WAKE], cfg.wakeup_hold_ticks))
                begin
                    wake_hold_next  = 1'b0;
                    en_next[T_WAKE] = 1'b0;
                end
                if (diag_hold_next && gt(cnt_next[T_DIAG], cfg.diag_hold_ticks))
                begin
                    diag_hold_next  = 1'b0;
                    en_next[T_DIAG] = 1'b0;
                end

                net_req = local_req_next || ((mode_reg == MODE_READY) && diag_hold_next);
                net_rel = !local_req_next && !diag_hold_next;
                passive = item.rx_valid && (item.rx_id_low == item.rx_byte0)
                          && (item.rx_length == FULL_DLC);
                rx_rep  = item.rx_valid
                          && ((rx_ctl_next == CTL_REPEAT) || (rx_ctl_next == RX_CTL_MASK));

                unique case (mode_reg)
                    MODE_OFF:
                    begin
                        if (work_on_reg)
                        begin
                            if (item.bus_wakeup)
                            begin
                                res.wakeup_consumed = 1'b1;
                                wake_hold_next      = 1'b1;
                                cnt_next[T_WAKE]    = '0;
                                en_next[T_WAKE]     = 1'b1;
                            end
                            else
                                local_req_next = 1'b1;
                            app_en_next  = 1'b0;
                            mode_next    = MODE_SLEEP;
                            en_next[3:0] = mode_en(MODE_SLEEP);
                        end
                    end
                    MODE_SLEEP:
                    begin
                        if (passive)
                            enter_rep = 1'b1;
                        else if (net_req)
                        begin
                            wake_hold_next = 1'b0;
                            enter_rep      = 1'b1;
                            enter_act      = 1'b1;
                        end
                    end
                    MODE_REPEAT:
                    begin
                        wake_hold_next = 1'b0;
                        if (imm_reg != '0)
                        begin
                            if (ge(cnt_next[T_MSG], cfg.immediate_cycle_ticks))
                            begin
                                imm_next           = imm_reg - 1'b1;
                                cnt_next[T_MSG]    = '0;
                                res.tx_send        = 1'b1;
                                res.tx_data1       = tx_ctl_reg;
                                res.tx_repeat_flag = 1'b1;
                            end
                        end
                        else if (ge(cnt_next[T_MSG], cfg.message_cycle_ticks))
                        begin
                            cnt_next[T_MSG]    = '0;
                            res.tx_send        = 1'b1;
                            res.tx_data1       = tx_ctl_reg;
                            res.tx_repeat_flag = 1'b1;
                        end
                        if (ge(cnt_next[T_TIMEOUT], cfg.timeout_ticks))
                            cnt_next[T_TIMEOUT] = '0;
                        if (ge(cnt_next[T_REPEAT], cfg.repeat_message_ticks))
                        begin
                            if (net_req)
                            begin
                                tx_ctl_next  = tx_ctl_reg & CTL_ACTIVE;
                                mode_next    = MODE_NORMAL;
                                en_next[3:0] = mode_en(MODE_NORMAL);
                            end
                            else if (net_rel)
                            begin
                                tx_ctl_next  = tx_ctl_reg & CTL_ACTIVE;
                                mode_next    = MODE_READY;
                                en_next[3:0] = mode_en(MODE_READY);
                            end
                        end
                    end
                    MODE_NORMAL:
                    begin
                        if (ge(cnt_next[T_MSG], cfg.message_cycle_ticks))
                        begin
                            cnt_next[T_MSG] = '0;
                            res.tx_send     = 1'b1;
                            res.tx_data1    = tx_ctl_reg;
                        end
                        if (ge(cnt_next[T_TIMEOUT], cfg.timeout_ticks))
                            cnt_next[T_TIMEOUT] = '0;
                        if (rx_rep)
                        begin
                            imm_next           = '0;
                            cnt_next[T_REPEAT] = '0;
                            cnt_next[T_MSG]    = ld(cfg.message_cycle_ticks);
                            mode_next          = MODE_REPEAT;
                            en_next[3:0]       = mode_en(MODE_REPEAT);
                        end
                        else if (net_rel)
                        begin
                            mode_next    = MODE_READY;
                            en_next[3:0] = mode_en(MODE_READY);
                        end
                    end
                    MODE_READY:
                    begin
                        if (ge(cnt_next[T_TIMEOUT], cfg.timeout_ticks))
                        begin
                            cnt_next[T_WAIT] = '0;
                            app_en_next      = 1'b0;
                            mode_next        = MODE_PREPARE;
                            en_next[3:0]     = mode_en(MODE_PREPARE);
                        end
                        else if (rx_rep)
                        begin
                            imm_next            = '0;
                            cnt_next[T_TIMEOUT] = '0;
                            cnt_next[T_REPEAT]  = '0;
                            cnt_next[T_MSG]     = ld(cfg.message_cycle_ticks);
                            mode_next           = MODE_REPEAT;
                            en_next[3:0]        = mode_en(MODE_REPEAT);
                        end
                        else if (net_req)
                        begin
                            cnt_next[T_TIMEOUT] = '0;
                            cnt_next[T_MSG]     = ld(cfg.message_cycle_ticks);
                            mode_next           = MODE_NORMAL;
                            en_next[3:0]        = mode_en(MODE_NORMAL);
                        end
                    end
                    MODE_PREPARE:
                    begin
                        if (ge(cnt_next[T_WAIT], cfg.wait_bus_sleep_ticks))
                        begin
                            app_en_next       = 1'b0;
                            mode_next         = MODE_SLEEP;
                            en_next[3:0]      = mode_en(MODE_SLEEP);
                            res.clear_buffers = 1'b1;
                        end
                        else if (net_req)
                        begin
                            enter_rep = 1'b1;
                            enter_act = 1'b1;
                        end
                        else if (passive)
                            enter_rep = 1'b1;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase

                if (enter_rep)
                begin
                    app_en_next         = 1'b1;
                    tx_ctl_next         = enter_act ? CTL_ACTIVE : '0;
                    imm_next            = enter_act ? BYTE_W'(IMMEDIATE_COUNT) : '0;
                    cnt_next[T_TIMEOUT] = '0;
                    cnt_next[T_REPEAT]  = '0;
                    cnt_next[T_MSG]     = ld(cfg.message_cycle_ticks);
                    mode_next           = MODE_REPEAT;
                    en_next[3:0]        = mode_en(MODE_REPEAT);
                end

                // any NM traffic restarts the timeout in the awake states
                if (is_active_mode(mode_next) && (rx_seen_next || tx_seen_next))
                begin
                    cnt_next[T_TIMEOUT] = '0;
                    rx_seen_next        = 1'b0;
                    tx_seen_next        = 1'b0;
                end
            end
            FN_START:
            begin
                work_on_next = 1'b1;
            end
            FN_STOP:
            begin
                work_on_next = 1'b0;
                app_en_next  = 1'b0;
                mode_next    = MODE_OFF;
                en_next[3:0] = mode_en(MODE_OFF);
            end
            FN_WAKEUP:
            begin
                if (!work_on_reg)
                begin
                    mode_next    = MODE_SLEEP;
                    en_next[3:0] = mode_en(MODE_SLEEP);
                end
                if (item.bus_wakeup)
                begin
                    res.wakeup_consumed = 1'b1;
                    wake_hold_next      = 1'b1;
                    cnt_next[T_WAKE]    = '0;
                    en_next[T_WAKE]     = 1'b1;
                end
                else
                    local_req_next = 1'b1;
            end
            FN_RELEASE:
            begin
                local_req_next = 1'b0;
            end
            FN_SLEEPED:
            begin
                app_en_next  = 1'b0;
                mode_next    = MODE_SLEEP;
                en_next[3:0] = mode_en(MODE_SLEEP);
            end
            FN_TX_CONFIRM:
            begin
                tx_seen_next = 1'b1;
            end
            default:
            begin
                tx_seen_next = tx_seen_reg;
            end
        endcase

        res.nm_mode     = mode_next;
        res.tx_data0    = res.tx_send ? cfg.node_id : '0;
        res.app_comm_on = app_en_next;
        res.tx_allowed  = is_active_mode(mode_next);
        res.may_sleep   = (mode_next == MODE_SLEEP) && !wake_hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            cnt_reg       <= '0;
            en_reg        <= '0;
            work_on_reg   <= 1'b0;
            wake_hold_reg <= 1'b0;
            local_req_reg <= 1'b0;
            diag_hold_reg <= 1'b0;
            rx_seen_reg   <= 1'b0;
            tx_seen_reg   <= 1'b0;
            rx_ctl_reg    <= '0;
            tx_ctl_reg    <= '0;
            imm_reg       <= '0;
            app_en_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            cnt_reg       <= cnt_next;
            en_reg        <= en_next;
            work_on_reg   <= work_on_next;
            wake_hold_reg <= wake_hold_next;
            local_req_reg <= local_req_next;
            diag_hold_reg <= diag_hold_next;
            rx_seen_reg   <= rx_seen_next;
            tx_seen_reg   <= tx_seen_next;
            rx_ctl_reg    <= rx_ctl_next;
            tx_ctl_reg    <= tx_ctl_next;
            imm_reg       <= imm_next;
            app_en_reg    <= app_en_next;
        end
    end

endmodule

// ----- dv/tb_can_network_management_fsm_top.sv -----
`timescale 1ns / 1ps
// Testbench for the CAN NM state machine top: directed table, then random event words per config.
module tb_can_network_management_fsm_top;
    import cnmf_pkg::*;

    localparam int NUM_REGS        = 8;
    localparam int RAND_PHASES     = 7;
    localparam int WORDS_PER_PHASE = 107;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int DIR_N           = 25;
    localparam logic [CFG_W-1:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        item_t   ev;
        logic    typed;
        result_t res;
    } dir_row_t;

    localparam result_t R_OFF =
        '{MODE_OFF, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam result_t R_ASLEEP =
        '{MODE_SLEEP, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam result_t R_WOKEN =
        '{MODE_SLEEP, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    // func, rx_valid, rx_id_low, rx_byte0, rx_byte1, rx_length, diag_event, bus_wakeup
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b1, R_OFF},
        '{'{FN_MAIN,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b1, R_OFF},
        '{'{FN_STOP,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b1, R_OFF},
        '{'{FN_SLEEPED,    1'b1, 8'hFF, 8'hFF, 8'hFF, 4'hF, 1'b1, 1'b1}, 1'b1, R_ASLEEP},
        '{'{FN_WAKEUP,     1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b1}, 1'b1, R_WOKEN},
        '{'{FN_MAIN,       1'b1, 8'h3C, 8'h3C, 8'h00, 4'd8, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TX_CONFIRM, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b1, 1'b0}, 1'b0, R_OFF},
        '{'{FN_START,      1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b1}, 1'b0, R_OFF},
        '{'{FN_STOP,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b1, R_OFF},
        '{'{FN_START,      1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b1, 8'h00, 8'h00, 8'h11, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b1, 8'h81, 8'h81, 8'h01, 4'hF, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_RELEASE,    1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TICK,       1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_MAIN,       1'b1, 8'hFF, 8'hFF, 8'hFF, 4'd8, 1'b0, 1'b0}, 1'b0, R_OFF},
        '{'{FN_TX_CONFIRM, 1'b0, 8'h00, 8'h00, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, R_OFF}
    };

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index  = '0;
    logic [CFG_W-1:0]  cfg_data   = '0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic [2:0]        func       = '0;
    logic              rx_valid   = 1'b0;
    logic [BYTE_W-1:0] rx_id_low  = '0;
    logic [BYTE_W-1:0] rx_byte0   = '0;
    logic [BYTE_W-1:0] rx_byte1   = '0;
    logic [DLC_W-1:0]  rx_length  = '0;
    logic              diag_event = 1'b0;
    logic              bus_wakeup = 1'b0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [2:0]        nm_mode;
    logic              tx_send;
    logic [BYTE_W-1:0] tx_data0;
    logic [BYTE_W-1:0] tx_data1;
    logic              tx_repeat_flag;
    logic              app_comm_on;
    logic              tx_allowed;
    logic              may_sleep;
    logic              clear_buffers;
    logic              wakeup_consumed;
    logic              diag_consumed;

    can_network_management_fsm_top dut (.*);

    // node model state
    cfg_t                    nm_cfg;
    mode_t                   nm_state;
    logic [CFG_W-1:0]        nm_tmr [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   nm_tmr_en;
    logic                    nm_running, nm_wake_hold, nm_local_req, nm_diag_hold;
    logic                    nm_rx_seen, nm_tx_seen, nm_app_en;
    logic [BYTE_W-1:0]       nm_rx_ctl, nm_tx_ctl, nm_imm_left;
    logic                    ev_send, ev_rep, ev_clear, ev_wake, ev_diag;
    logic [BYTE_W-1:0]       ev_ctl;

    result_t          pending_status [$];
    logic [CFG_W-1:0] cfg_plan [NUM_REGS];
    int               mismatches = 0;
    int               idle_cycles = 0;
    logic             src_calm = 1'b0;
    logic             snk_calm = 1'b0;

    function automatic logic carries_traffic(mode_t m);
        return (m == MODE_REPEAT) || (m == MODE_NORMAL) || (m == MODE_READY);
    endfunction

    function automatic void enter_mode(mode_t m);
        nm_state = m;
        nm_tmr_en[T_TIMEOUT] = carries_traffic(m);
        nm_tmr_en[T_MSG]     = (m == MODE_REPEAT) || (m == MODE_NORMAL);
        nm_tmr_en[T_REPEAT]  = (m == MODE_REPEAT);
        nm_tmr_en[T_WAIT]    = (m == MODE_PREPARE);
    endfunction

    function automatic logic net_requested();
        return nm_local_req || (nm_state == MODE_READY && nm_diag_hold);
    endfunction

    function automatic logic net_released();
        return !nm_local_req && !nm_diag_hold;
    endfunction

    function automatic logic passive_frame(item_t it);
        return nm_rx_seen && it.rx_id_low == it.rx_byte0 && it.rx_length == FULL_DLC;
    endfunction

    function automatic logic repeat_requested();
        return nm_rx_seen && (nm_rx_ctl == CTL_REPEAT || nm_rx_ctl == (CTL_REPEAT | CTL_ACTIVE));
    endfunction

    function automatic void send_nm_frame();
        ev_send = 1'b1;
        ev_ctl  = nm_tx_ctl;
        ev_rep  = (nm_state == MODE_REPEAT);
    endfunction

    function automatic void take_wakeup(logic wake);
        if (wake)
        begin
            ev_wake = 1'b1;
            nm_wake_hold = 1'b1;
            nm_tmr[T_WAKE] = '0;
            nm_tmr_en[T_WAKE] = 1'b1;
        end
        else
        begin
            nm_local_req = 1'b1;
        end
    endfunction

    function automatic void enter_repeat(logic active);
        nm_app_en = 1'b1;
        nm_tx_ctl = active ? CTL_ACTIVE : '0;
        nm_imm_left = active ? BYTE_W'(IMMEDIATE_COUNT_DEF) : '0;
        nm_tmr[T_TIMEOUT] = '0;
        nm_tmr[T_REPEAT] = '0;
        nm_tmr[T_MSG] = nm_cfg.message_cycle_ticks;
        enter_mode(MODE_REPEAT);
    endfunction

    task automatic run_nm_event(input item_t it, output result_t r);
        int i;
        ev_send = 1'b0;
        ev_rep = 1'b0;
        ev_clear = 1'b0;
        ev_wake = 1'b0;
        ev_diag = 1'b0;
        ev_ctl = '0;
        case (it.func)
            FN_TICK:
            begin
                for (i = 0; i < NUM_TIMERS; i++)
                    if (nm_tmr_en[i] && nm_tmr[i] != TICK_MAX)
                        nm_tmr[i] = nm_tmr[i] + 1'b1;
            end
            FN_MAIN:
            begin
                nm_rx_seen = it.rx_valid;
                nm_rx_ctl = it.rx_valid ? (it.rx_byte1 & RX_CTL_MASK) : '0;
                if (it.diag_event)
                begin
                    ev_diag = 1'b1;
                    nm_tmr[T_DIAG] = '0;
                    nm_tmr_en[T_DIAG] = 1'b1;
                    nm_diag_hold = 1'b1;
                end
                if (nm_wake_hold && nm_tmr[T_WAKE] > nm_cfg.wakeup_hold_ticks)
                begin
                    nm_wake_hold = 1'b0;
                    nm_tmr_en[T_WAKE] = 1'b0;
                end
                if (nm_diag_hold && nm_tmr[T_DIAG] > nm_cfg.diag_hold_ticks)
                begin
                    nm_diag_hold = 1'b0;
                    nm_tmr_en[T_DIAG] = 1'b0;
                end
                case (nm_state)
                    MODE_OFF:
                    begin
                        if (nm_running)
                        begin
                            take_wakeup(it.bus_wakeup);
                            nm_app_en = 1'b0;
                            enter_mode(MODE_SLEEP);
                        end
                    end
                    MODE_SLEEP:
                    begin
                        if (passive_frame(it))
                            enter_repeat(1'b0);
                        else if (net_requested())
                        begin
                            nm_wake_hold = 1'b0;
                            enter_repeat(1'b1);
                        end
                    end
                    MODE_REPEAT:
                    begin
                        nm_wake_hold = 1'b0;
                        if (nm_imm_left != 0)
                        begin
                            if (nm_tmr[T_MSG] >= nm_cfg.immediate_cycle_ticks)
                            begin
                                nm_imm_left = nm_imm_left - 1'b1;
                                nm_tmr[T_MSG] = '0;
                                send_nm_frame();
                            end
                        end
                        else if (nm_tmr[T_MSG] >= nm_cfg.message_cycle_ticks)
                        begin
                            nm_tmr[T_MSG] = '0;
                            send_nm_frame();
                        end
                        if (nm_tmr[T_TIMEOUT] >= nm_cfg.timeout_ticks)
                            nm_tmr[T_TIMEOUT] = '0;
                        if (nm_tmr[T_REPEAT] >= nm_cfg.repeat_message_ticks)
                        begin
                            if (net_requested())
                            begin
                                nm_tx_ctl = nm_tx_ctl & CTL_ACTIVE;
                                enter_mode(MODE_NORMAL);
                            end
                            else if (net_released())
                            begin
                                nm_tx_ctl = nm_tx_ctl & CTL_ACTIVE;
                                enter_mode(MODE_READY);
                            end
                        end
                    end
                    MODE_NORMAL:
                    begin
                        if (nm_tmr[T_MSG] >= nm_cfg.message_cycle_ticks)
                        begin
                            nm_tmr[T_MSG] = '0;
                            send_nm_frame();
                        end
                        if (nm_tmr[T_TIMEOUT] >= nm_cfg.timeout_ticks)
                            nm_tmr[T_TIMEOUT] = '0;
                        if (repeat_requested())
                        begin
                            nm_imm_left = '0;
                            nm_tmr[T_REPEAT] = '0;
                            nm_tmr[T_MSG] = nm_cfg.message_cycle_ticks;
                            enter_mode(MODE_REPEAT);
                        end
                        else if (net_released())
                            enter_mode(MODE_READY);
                    end
                    MODE_READY:
                    begin
                        if (nm_tmr[T_TIMEOUT] >= nm_cfg.timeout_ticks)
                        begin
                            nm_tmr[T_WAIT] = '0;
                            nm_app_en = 1'b0;
                            enter_mode(MODE_PREPARE);
                        end
                        else if (repeat_requested())
                        begin
                            nm_imm_left = '0;
                            nm_tmr[T_TIMEOUT] = '0;
                            nm_tmr[T_REPEAT] = '0;
                            nm_tmr[T_MSG] = nm_cfg.message_cycle_ticks;
                            enter_mode(MODE_REPEAT);
                        end
                        else if (net_requested())
                        begin
                            nm_tmr[T_TIMEOUT] = '0;
                            nm_tmr[T_MSG] = nm_cfg.message_cycle_ticks;
                            enter_mode(MODE_NORMAL);
                        end
                    end
                    MODE_PREPARE:
                    begin
                        if (nm_tmr[T_WAIT] >= nm_cfg.wait_bus_sleep_ticks)
                        begin
                            nm_app_en = 1'b0;
                            enter_mode(MODE_SLEEP);
                            ev_clear = 1'b1;
                        end
                        else if (net_requested())
                            enter_repeat(1'b1);
                        else if (passive_frame(it))
                            enter_repeat(1'b0);
                    end
                    default: ;
                endcase
                if (carries_traffic(nm_state) && (nm_rx_seen || nm_tx_seen))
                begin
                    nm_tmr[T_TIMEOUT] = '0;
                    nm_rx_seen = 1'b0;
                    nm_tx_seen = 1'b0;
                end
            end
            FN_START: nm_running = 1'b1;
            FN_STOP:
            begin
                nm_running = 1'b0;
                nm_app_en = 1'b0;
                enter_mode(MODE_OFF);
            end
            FN_WAKEUP:
            begin
                if (!nm_running)
                    enter_mode(MODE_SLEEP);
                take_wakeup(it.bus_wakeup);
            end
            FN_RELEASE: nm_local_req = 1'b0;
            FN_SLEEPED:
            begin
                nm_app_en = 1'b0;
                enter_mode(MODE_SLEEP);
            end
            default: nm_tx_seen = 1'b1;
        endcase

        r.nm_mode         = nm_state;
        r.tx_send         = ev_send;
        r.tx_data0        = ev_send ? nm_cfg.node_id : '0;
        r.tx_data1        = ev_send ? ev_ctl : '0;
        r.tx_repeat_flag  = ev_send && ev_rep;
        r.app_comm_on     = nm_app_en;
        r.tx_allowed      = carries_traffic(nm_state);
        r.may_sleep       = (nm_state == MODE_SLEEP) && !nm_wake_hold;
        r.clear_buffers   = ev_clear;
        r.wakeup_consumed = ev_wake;
        r.diag_consumed   = ev_diag;
    endtask

    function automatic item_t rand_event(func_t f);
        item_t it;
        it.func       = f;
        it.rx_valid   = 1'($urandom_range(0, 1));
        it.rx_id_low  = 8'($urandom);
        it.rx_byte0   = ($urandom_range(0, 3) == 0) ? it.rx_id_low : 8'($urandom);
        it.rx_byte1   = 8'($urandom);
        it.rx_length  = 4'($urandom);
        it.diag_event = ($urandom_range(0, 9) == 0);
        it.bus_wakeup = 1'($urandom_range(0, 1));
        if (f == FN_MAIN && $urandom_range(0, 1) != 0)
        begin
            it.rx_valid  = 1'b1;
            it.rx_byte0  = it.rx_id_low;
            it.rx_length = FULL_DLC;
            // keep repeat requests rare so the node can settle
            if ($urandom_range(0, 3) != 0)
                it.rx_byte1 = it.rx_byte1 & ~CTL_REPEAT;
        end
        return it;
    endfunction

    task automatic send_event(input item_t it, input logic use_given, input result_t given);
        int gap;
        result_t pred;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= it.func;
        rx_valid   <= it.rx_valid;
        rx_id_low  <= it.rx_id_low;
        rx_byte0   <= it.rx_byte0;
        rx_byte1   <= it.rx_byte1;
        rx_length  <= it.rx_length;
        diag_event <= it.diag_event;
        bus_wakeup <= it.bus_wakeup;
        do @(posedge clk); while (in_stall);
        run_nm_event(it, pred);
        pending_status.push_back(use_given ? given : pred);
    endtask

    task automatic load_config();
        int k;
        for (k = 0; k < NUM_REGS; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(k);
            cfg_data  <= cfg_plan[k];
            do @(posedge clk); while (!cfg_ready);
            case (cfg_idx_t'(k))
                REG_NODE_ID:     nm_cfg.node_id = cfg_plan[k][BYTE_W-1:0];
                REG_MSG_CYCLE:   nm_cfg.message_cycle_ticks = cfg_plan[k];
                REG_IMM_CYCLE:   nm_cfg.immediate_cycle_ticks = cfg_plan[k];
                REG_TIMEOUT:     nm_cfg.timeout_ticks = cfg_plan[k];
                REG_REPEAT_MSG:  nm_cfg.repeat_message_ticks = cfg_plan[k];
                REG_WAIT_SLEEP:  nm_cfg.wait_bus_sleep_ticks = cfg_plan[k];
                REG_WAKEUP_HOLD: nm_cfg.wakeup_hold_ticks = cfg_plan[k];
                default:         nm_cfg.diag_hold_ticks = cfg_plan[k];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no progress, %0d words outstanding", $time,
                     pending_status.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin : status_sink
        result_t want;
        result_t got;
        int n;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                snk_calm = !snk_calm;
            n = snk_calm ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = {mode_t'(nm_mode), tx_send, tx_data0, tx_data1, tx_repeat_flag,
                   app_comm_on, tx_allowed, may_sleep, clear_buffers,
                   wakeup_consumed, diag_consumed};
            if (pending_status.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: word expected none actual mode %0d", $time, nm_mode);
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("nm_mode", want.nm_mode, got.nm_mode);
                check_field("tx_send", want.tx_send, got.tx_send);
                check_field("tx_data0", want.tx_data0, got.tx_data0);
                check_field("tx_data1", want.tx_data1, got.tx_data1);
                check_field("tx_repeat_flag", want.tx_repeat_flag, got.tx_repeat_flag);
                check_field("app_comm_on", want.app_comm_on, got.app_comm_on);
                check_field("tx_allowed", want.tx_allowed, got.tx_allowed);
                check_field("may_sleep", want.may_sleep, got.may_sleep);
                check_field("clear_buffers", want.clear_buffers, got.clear_buffers);
                check_field("wakeup_consumed", want.wakeup_consumed, got.wakeup_consumed);
                check_field("diag_consumed", want.diag_consumed, got.diag_consumed);
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int k;
        int r;
        func_t f;
        item_t ev;
        item_t burst [$];

        nm_cfg = '{8'd0, 16'd100, 16'd20, 16'd200, 16'd150, 16'd200, 16'd100, 16'd500};
        nm_state = MODE_OFF;
        for (k = 0; k < NUM_TIMERS; k++)
            nm_tmr[k] = '0;
        nm_tmr_en = '0;
        nm_running = 1'b0;
        nm_wake_hold = 1'b0;
        nm_local_req = 1'b0;
        nm_diag_hold = 1'b0;
        nm_rx_seen = 1'b0;
        nm_tx_seen = 1'b0;
        nm_app_en = 1'b0;
        nm_rx_ctl = '0;
        nm_tx_ctl = '0;
        nm_imm_left = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            in_valid <= 1'b0;
            while (pending_status.size() != 0)
                @(posedge clk);
            case (ph)
                0: cfg_plan = '{16'hFF5A, 16'd2, 16'd1, 16'd4, 16'd2, 16'd1, 16'd1, 16'd2};
                1: cfg_plan = '{16'd0, 16'd100, 16'd20, 16'd200, 16'd150, 16'd200,
                                16'd100, 16'd500};
                2: cfg_plan = '{default: 16'h0000};
                3: cfg_plan = '{default: TICK_MAX};
                default:
                begin
                    for (k = 0; k < NUM_REGS; k++)
                        cfg_plan[k] = (cfg_idx_t'(k) == REG_NODE_ID) ?
                                      16'($urandom) : 16'($urandom_range(0, 12));
                end
            endcase
            load_config();

            if (ph == 0)
                for (k = 0; k < DIR_N; k++)
                    send_event(DIR_ROWS[k].ev, DIR_ROWS[k].typed, DIR_ROWS[k].res);

            for (k = 0; k < WORDS_PER_PHASE; k++)
            begin
                if (burst.size() == 0)
                begin
                    if ($urandom_range(0, 24) == 0)
                    begin
                        // bring-up: start, leave off, local request, enter repeat
                        burst.push_back(rand_event(FN_START));
                        burst.push_back(rand_event(FN_MAIN));
                        ev = rand_event(FN_WAKEUP);
                        ev.bus_wakeup = 1'b0;
                        burst.push_back(ev);
                        burst.push_back(rand_event(FN_MAIN));
                    end
                    else
                    begin
                        r = $urandom_range(0, 99);
                        f = (r < 45) ? FN_TICK :
                            (r < 80) ? FN_MAIN :
                            (r < 84) ? FN_START :
                            (r < 86) ? FN_STOP :
                            (r < 90) ? FN_WAKEUP :
                            (r < 95) ? FN_RELEASE :
                            (r < 96) ? FN_SLEEPED : FN_TX_CONFIRM;
                        burst.push_back(rand_event(f));
                    end
                end
                send_event(burst.pop_front(), 1'b0, R_OFF);
            end
        end

        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cnmf_pkg.sv
src/cnmf_cfg.sv
src/cnmf_engine.sv
src/can_network_management_fsm_top.sv
dv/tb_can_network_management_fsm_top.sv
